>>> hw/rtl/gradient_line_rasterizer_core_assert.svh
// Assertion macros used by the line rasterizer controller.
`ifndef GRADIENT_LINE_RASTERIZER_CORE_ASSERT_SVH
`define GRADIENT_LINE_RASTERIZER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define GLR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("line rasterizer assertion failed");
// Condition that must hold in the cycle after a trigger.
`define GLR_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("line rasterizer assertion failed");
`else
`define GLR_ASSERT(name, prop)
`define GLR_ASSERT_NEXT(name, pre, post)
`endif
`endif

>>> hw/rtl/glr_pkg.sv
// Shared types, constants and helper functions of the line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package glr_pkg;

  // Geometry and color formats.
  localparam int unsigned COORD_BITS_DEF = 13;
  localparam int unsigned WIDTH_BITS     = 12;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 12'd1920;
  localparam int unsigned COLOR_W        = 32;
  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned NUM_CHANNELS   = 3;
  localparam int unsigned DELTA_W        = CHAN_W + 1;

  // Blend fraction in tenths, and the walk position counter.
  localparam int unsigned FRAC_W     = 4;
  localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd10;
  localparam int unsigned STEP_BITS  = 14;
  localparam int unsigned FRAC_NUM_W = STEP_BITS + 4;

  // Channel delta times fraction, and its magnitude.
  localparam int unsigned PROD_W = DELTA_W + FRAC_W + 1;
  localparam int unsigned MAG_W  = 12;

  // Reciprocal of ten in 16 fractional bits; exact for magnitudes below 4096.
  localparam int unsigned DIV10_SHIFT = 16;
  localparam int unsigned RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] DIV10_RECIP = 13'd6554;

  // Command codes carried in the input tuser.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCALE,
    ST_EMIT
  } glr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic walk;
    logic finish;
    logic take_frac;
    logic scale;
    logic emit;
  } glr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;
    logic at_target;
    logic div_done;
    logic out_free;
  } glr_status_t;

  // Unsigned division by ten through a reciprocal multiply.
  function automatic logic [CHAN_W-1:0] div10(input logic [MAG_W-1:0] mag);
    logic [MAG_W+RECIP_W-1:0] prod;
    prod = (MAG_W + RECIP_W)'(mag) * (MAG_W + RECIP_W)'(DIV10_RECIP);
    return prod[DIV10_SHIFT +: CHAN_W];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/glr_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module glr_divider #(
  parameter int unsigned NUM_W = glr_pkg::FRAC_NUM_W,
  parameter int unsigned DEN_W = glr_pkg::COORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quot_o,
  output logic             done_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fit;
  logic [DEN_W-1:0] rem_d;

  // One trial subtraction of the shifted remainder.
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign fit     = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign rem_d   = fit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Numerator shifts out at the top while quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fit};
      rem_q <= rem_d;
    end
  end

  assign quot_o = num_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> hw/rtl/glr_datapath.sv
// Line walker registers, blend fraction divider, color blend and output register.
`timescale 1ns / 1ps
`default_nettype none

module glr_datapath #(
  parameter int unsigned COORD_BITS = glr_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  glr_pkg::glr_cmd_t                 cmd_i,
  output glr_pkg::glr_status_t              status_o,
  input  logic                              cfg_we_i,
  input  logic [glr_pkg::WIDTH_BITS-1:0]    cfg_wdata_i,
  input  logic signed [COORD_BITS-1:0]      x_start_i,
  input  logic signed [COORD_BITS-1:0]      y_start_i,
  input  logic signed [COORD_BITS-1:0]      x_end_i,
  input  logic signed [COORD_BITS-1:0]      y_end_i,
  input  logic [glr_pkg::COLOR_W-1:0]       start_color_i,
  input  logic [glr_pkg::COLOR_W-1:0]       end_color_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [COORD_BITS-1:0]             pixel_x_o,
  output logic [COORD_BITS-1:0]             pixel_y_o,
  output logic [glr_pkg::COLOR_W-1:0]       pixel_color_o,
  output logic                              last_pixel_o
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned ERR_W  = C + 2;
  localparam int unsigned CMP_W  = (C > glr_pkg::WIDTH_BITS ? C : glr_pkg::WIDTH_BITS) + 1;
  localparam int unsigned NUM_W  = glr_pkg::FRAC_NUM_W;
  localparam int unsigned CH_W   = glr_pkg::CHAN_W;
  localparam int unsigned NCH    = glr_pkg::NUM_CHANNELS;

  // Control registers.
  logic                            active_q;
  logic [glr_pkg::WIDTH_BITS-1:0]  width_q;
  logic                            out_valid_q;

  // Walker and blend payload registers.
  logic signed [C-1:0]             cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
  logic [C-1:0]                    span_x_q, span_y_q, len_q;
  logic                            dir_x_neg_q, dir_y_neg_q;
  logic signed [ERR_W-1:0]         err_q;
  logic [glr_pkg::STEP_BITS-1:0]   step_q;
  logic [glr_pkg::COLOR_W-1:0]     base_q;
  logic signed [glr_pkg::DELTA_W-1:0] delta_q [NCH];
  logic [glr_pkg::FRAC_W-1:0]      frac_q;
  logic signed [glr_pkg::PROD_W-1:0] prod_q [NCH];
  logic [C-1:0]                    pix_x_q, pix_y_q;
  logic                            last_q;
  logic [C-1:0]                    out_x_q, out_y_q;
  logic [glr_pkg::COLOR_W-1:0]     out_color_q;
  logic                            out_last_q;

  // Start-side values.
  logic signed [CMP_W-1:0]         xs_w, xe_w, w_w;
  logic                            reject;
  logic signed [C:0]               dx, dy, abs_dx, abs_dy;
  logic [C-1:0]                    span_x_n, span_y_n, len_n;
  logic signed [ERR_W-1:0]         err_n;
  logic signed [glr_pkg::DELTA_W-1:0] delta_n [NCH];

  // Walk-side values.
  logic signed [ERR_W:0]           e2, sx_e, sy_e;
  logic                            move_x, move_y;
  logic signed [ERR_W-1:0]         err_sub, err_add, err_walk;
  logic signed [C-1:0]             x_next, y_next;
  logic [glr_pkg::STEP_BITS-1:0]   step_next;
  logic [NUM_W-1:0]                div_num, quot;
  logic                            div_done;

  // Blend values.
  logic                            prod_neg [NCH];
  logic [glr_pkg::PROD_W-1:0]      prod_mag [NCH];
  logic [CH_W-1:0]                 quo10 [NCH];
  logic [CH_W-1:0]                 term [NCH];
  logic [CH_W-1:0]                 chan [NCH];
  logic [glr_pkg::COLOR_W-1:0]     color_n;

  // Rejection of lines lying wholly left of 0 or right of the window.
  assign xs_w   = CMP_W'(x_start_i);
  assign xe_w   = CMP_W'(x_end_i);
  assign w_w    = $signed({{(CMP_W - glr_pkg::WIDTH_BITS){1'b0}}, width_q});
  assign reject = (x_start_i[C-1] && x_end_i[C-1]) || ((xs_w > w_w) && (xe_w > w_w));

  // Spans, directions, initial error and length.
  assign dx       = (C + 1)'(x_end_i) - (C + 1)'(x_start_i);
  assign dy       = (C + 1)'(y_end_i) - (C + 1)'(y_start_i);
  assign abs_dx   = dx[C] ? -dx : dx;
  assign abs_dy   = dy[C] ? -dy : dy;
  assign span_x_n = abs_dx[C-1:0];
  assign span_y_n = abs_dy[C-1:0];
  assign len_n    = (span_x_n > span_y_n) ? span_x_n : span_y_n;
  assign err_n    = $signed({2'b00, span_x_n}) - $signed({2'b00, span_y_n});

  // Bresenham decisions for one step.
  assign e2       = {err_q, 1'b0};
  assign sx_e     = $signed({3'b000, span_x_q});
  assign sy_e     = $signed({3'b000, span_y_q});
  assign move_x   = e2 > -sy_e;
  assign move_y   = e2 < sx_e;
  assign err_sub  = move_x ? $signed({2'b00, span_y_q}) : '0;
  assign err_add  = move_y ? $signed({2'b00, span_x_q}) : '0;
  assign err_walk = err_q - err_sub + err_add;
  assign x_next   = cur_x_q + (dir_x_neg_q ? {C{1'b1}} : C'(1));
  assign y_next   = cur_y_q + (dir_y_neg_q ? {C{1'b1}} : C'(1));

  // Numerator of the fraction is ten times the new position.
  assign step_next = step_q + 1'b1;
  assign div_num   = (NUM_W'(step_next) << 3) + (NUM_W'(step_next) << 1);

  glr_divider #(
    .NUM_W (NUM_W),
    .DEN_W (C)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.walk),
    .num_i   (div_num),
    .den_i   (len_q),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  // Per-channel delta at start, and truncating divide by ten at emit.
  for (genvar c = 0; c < NCH; c++) begin : g_chan
    localparam int unsigned SH = CH_W * (NCH - 1 - c);
    assign delta_n[c]  = $signed({1'b0, end_color_i[SH +: CH_W]})
                       - $signed({1'b0, start_color_i[SH +: CH_W]});
    assign prod_neg[c] = prod_q[c][glr_pkg::PROD_W-1];
    assign prod_mag[c] = prod_neg[c] ? -prod_q[c] : prod_q[c];
    assign quo10[c]    = glr_pkg::div10(prod_mag[c][glr_pkg::MAG_W-1:0]);
    assign term[c]     = prod_neg[c] ? -quo10[c] : quo10[c];
    assign chan[c]     = base_q[SH +: CH_W] + term[c];
  end

  // Alpha comes from the start color; channels are red, green, blue.
  assign color_n = {base_q[glr_pkg::COLOR_W-1 -: CH_W], chan[0], chan[1], chan[2]};

  // Control registers and the configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      width_q     <= glr_pkg::WIDTH_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        active_q <= !reject;
      end else if (cmd_i.finish) begin
        active_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walker state, blend pipeline and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_x_q     <= x_start_i;
      cur_y_q     <= y_start_i;
      tgt_x_q     <= x_end_i;
      tgt_y_q     <= y_end_i;
      span_x_q    <= span_x_n;
      span_y_q    <= span_y_n;
      dir_x_neg_q <= dx[C] || (dx == '0);
      dir_y_neg_q <= dy[C] || (dy == '0);
      err_q       <= err_n;
      step_q      <= '0;
      len_q       <= len_n;
      base_q      <= start_color_i;
      for (int c = 0; c < NCH; c++) begin
        delta_q[c] <= delta_n[c];
      end
    end
    if (cmd_i.walk) begin
      pix_x_q <= cur_x_q;
      pix_y_q <= cur_y_q;
      last_q  <= 1'b0;
      step_q  <= step_next;
      err_q   <= err_walk;
      if (move_x) begin
        cur_x_q <= x_next;
      end
      if (move_y) begin
        cur_y_q <= y_next;
      end
    end
    if (cmd_i.finish) begin
      pix_x_q <= tgt_x_q;
      pix_y_q <= tgt_y_q;
      last_q  <= 1'b1;
      frac_q  <= glr_pkg::FRAC_MAX;
    end
    if (cmd_i.take_frac) begin
      frac_q <= (quot > NUM_W'(glr_pkg::FRAC_MAX)) ? glr_pkg::FRAC_MAX
                                                  : quot[glr_pkg::FRAC_W-1:0];
    end
    if (cmd_i.scale) begin
      for (int c = 0; c < NCH; c++) begin
        prod_q[c] <= glr_pkg::PROD_W'(delta_q[c])
                   * $signed({{(glr_pkg::PROD_W - glr_pkg::FRAC_W){1'b0}}, frac_q});
      end
    end
    if (cmd_i.emit) begin
      out_x_q     <= pix_x_q;
      out_y_q     <= pix_y_q;
      out_color_q <= color_n;
      out_last_q  <= last_q;
    end
  end

  // Status toward the controller.
  assign status_o.active    = active_q;
  assign status_o.at_target = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = out_x_q;
  assign pixel_y_o     = out_y_q;
  assign pixel_color_o = out_color_q;
  assign last_pixel_o  = out_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/glr_ctrl.sv
// Controller state machine that sequences start, walk, divide, blend and emit.
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_line_rasterizer_core_assert.svh"

module glr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_cmd_i,
  output logic                 in_ready_o,
  input  glr_pkg::glr_status_t status_i,
  output glr_pkg::glr_cmd_t    cmd_o
);

  glr_pkg::glr_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      glr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_cmd_i)
            glr_pkg::CMD_START: begin
              cmd_o.load = 1'b1;
            end
            glr_pkg::CMD_STEP: begin
              if (status_i.active) begin
                if (status_i.at_target) begin
                  cmd_o.finish = 1'b1;
                  state_d      = glr_pkg::ST_SCALE;
                end else begin
                  cmd_o.walk = 1'b1;
                  state_d    = glr_pkg::ST_DIVIDE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      glr_pkg::ST_DIVIDE: begin
        if (status_i.div_done) begin
          cmd_o.take_frac = 1'b1;
          state_d         = glr_pkg::ST_SCALE;
        end
      end
      glr_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = glr_pkg::ST_EMIT;
      end
      glr_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = glr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = glr_pkg::ST_IDLE;
      end
    endcase
  end

  // The divider only finishes while the controller waits for it.
  `GLR_ASSERT(a_done_in_divide, status_i.div_done |-> (state_q == glr_pkg::ST_DIVIDE))
  // A result is never written over one that is still waiting.
  `GLR_ASSERT(a_emit_has_room, cmd_o.emit |-> status_i.out_free)
  // A walking step always starts the divider wait.
  `GLR_ASSERT_NEXT(a_walk_enters_divide, cmd_o.walk, state_q == glr_pkg::ST_DIVIDE)
  // The endpoint pixel ends the line.
  `GLR_ASSERT_NEXT(a_finish_clears_active, cmd_o.finish, !status_i.active)

endmodule

`default_nettype wire

>>> hw/rtl/gradient_line_rasterizer_core.sv
// Top level of the gradient line rasterizer: stream ports, controller and datapath.
//
// A start beat (tuser 0) loads two endpoints and two colors and never
// produces a pixel; a line lying wholly left of x = 0 or right of the window
// width is dropped. Each step beat (tuser 1) produces one pixel of the
// Bresenham walk with its blended color, and the last pixel of the line is
// flagged on tlast. A step beat that walks starts the bit-serial divider that
// forms the blend fraction, then passes through the divide, scale and emit
// states to the output register, and the next beat is taken once the
// controller is back in idle; the endpoint step passes through the scale and
// emit states only, and a start beat or a step with no line in progress is
// handled in the idle state. The input is accepted only while the controller
// is idle; a finished pixel waits in the output register without holding up
// the next input beat until the following pixel needs the register. The
// window width register may be written only while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none

module gradient_line_rasterizer_core #(
  parameter int unsigned COORD_BITS = glr_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_FIELDS_W  = 4 * COORD_BITS + 2 * glr_pkg::COLOR_W,
  localparam int unsigned IN_W         = ((IN_FIELDS_W + 7) / 8) * 8,
  localparam int unsigned OUT_FIELDS_W = 2 * COORD_BITS + glr_pkg::COLOR_W,
  localparam int unsigned OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [glr_pkg::WIDTH_BITS-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // x_start, y_start, x_end, y_end, start_color, end_color, zero fill
  input  logic [IN_W-1:0]                s_axis_tdata,
  // cmd
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero fill
  output logic [OUT_W-1:0]               m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int unsigned C = COORD_BITS;

  logic signed [C-1:0]          x_start, y_start, x_end, y_end;
  logic [glr_pkg::COLOR_W-1:0]  start_color, end_color;
  logic [C-1:0]                 pixel_x, pixel_y;
  logic [glr_pkg::COLOR_W-1:0]  pixel_color;
  glr_pkg::glr_cmd_t            cmd;
  glr_pkg::glr_status_t         status;

  // Unpack the input beat.
  assign x_start     = s_axis_tdata[0 +: C];
  assign y_start     = s_axis_tdata[C +: C];
  assign x_end       = s_axis_tdata[2 * C +: C];
  assign y_end       = s_axis_tdata[3 * C +: C];
  assign start_color = s_axis_tdata[4 * C +: glr_pkg::COLOR_W];
  assign end_color   = s_axis_tdata[4 * C + glr_pkg::COLOR_W +: glr_pkg::COLOR_W];

  glr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  glr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .x_start_i     (x_start),
    .y_start_i     (y_start),
    .x_end_i       (x_end),
    .y_end_i       (y_end),
    .start_color_i (start_color),
    .end_color_i   (end_color),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .last_pixel_o  (m_axis_tlast)
  );

  // Pack the output beat.
  assign m_axis_tdata = OUT_W'({pixel_color, pixel_y, pixel_x});

endmodule

`default_nettype wire

>>> dv/gradient_line_rasterizer_core_tb.sv
// Self-checking testbench for the gradient line rasterizer core.
`timescale 1ns / 1ps

module gradient_line_rasterizer_core_tb;

  localparam int COORD_W     = glr_pkg::COORD_BITS_DEF;
  localparam int IN_W        = ((4 * COORD_W + 2 * glr_pkg::COLOR_W + 7) / 8) * 8;
  localparam int OUT_W       = ((2 * COORD_W + glr_pkg::COLOR_W + 7) / 8) * 8;
  localparam int COORD_MIN   = -(1 << (COORD_W - 1));
  localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
  localparam int WIDTH_MAX   = (1 << glr_pkg::WIDTH_BITS) - 1;
  localparam int FULL_FRAC   = int'(glr_pkg::FRAC_MAX);
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_HEAVY  = 53;
  localparam int IDLE_BOTH   = 27;
  localparam int SETTLE_CYC  = 40;
  localparam int HOLD_CYC    = 400;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [31:0]        color;
    logic               last;
  } pixel_t;

  // Bresenham walker with color blend; queues the pixel each step should emit.
  class pixel_scoreboard;
    pixel_t                    expected_pixels[$];
    int unsigned               failures;
    int                        window_w;
    bit                        walking;
    logic signed [COORD_W-1:0] cur_x, cur_y, end_x, end_y;
    int                        span_x, span_y, err, len;
    bit                        neg_x, neg_y;
    logic [glr_pkg::STEP_BITS-1:0] pos;
    logic [31:0]               base;
    int                        delta[3];

    function new();
      window_w = int'(glr_pkg::WIDTH_RESET);
      failures = 0;
      walking  = 0;
    endfunction

    function void set_width(int w);
      window_w = w;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Alpha passes through; each RGB channel moves frac tenths of its delta.
    function logic [31:0] blend(int frac);
      logic [31:0] c;
      int          s, term, k;
      c = {base[31:24], 24'h0};
      for (k = 0; k < 3; k++) begin
        s    = int'(base[16-8*k +: 8]);
        term = (delta[k] * frac) / 10;
        c[16-8*k +: 8] = 8'(s + term);
      end
      return c;
    endfunction

    // Returns 1 when the accepted beat is expected to produce a pixel.
    function bit note_input(logic cmd, logic [COORD_W-1:0] xs, ys, xe, ye,
                            logic [31:0] sc, ec);
      int     ixs, iys, ixe, iye, e2, frac, k;
      pixel_t px;
      if (cmd == glr_pkg::CMD_START) begin
        ixs = int'($signed(xs));
        iys = int'($signed(ys));
        ixe = int'($signed(xe));
        iye = int'($signed(ye));
        if ((ixs < 0 && ixe < 0) || (ixs > window_w && ixe > window_w)) begin
          walking = 0;
          return 0;
        end
        cur_x  = xs;
        cur_y  = ys;
        end_x  = xe;
        end_y  = ye;
        span_x = (ixe > ixs) ? ixe - ixs : ixs - ixe;
        span_y = (iye > iys) ? iye - iys : iys - iye;
        neg_x  = !(ixs < ixe);
        neg_y  = !(iys < iye);
        err    = span_x - span_y;
        pos    = '0;
        len    = (span_x > span_y) ? span_x : span_y;
        base   = sc;
        for (k = 0; k < 3; k++)
          delta[k] = int'(ec[16-8*k +: 8]) - int'(sc[16-8*k +: 8]);
        walking = 1;
        return 0;
      end
      if (!walking)
        return 0;
      if (cur_x == end_x && cur_y == end_y) begin
        // Endpoint pixel carries the full end RGB color and closes the line.
        px.x     = end_x;
        px.y     = end_y;
        px.color = blend(FULL_FRAC);
        px.last  = 1'b1;
        walking  = 0;
      end else begin
        pos  = pos + 1'b1;
        frac = (len == 0) ? FULL_FRAC : (int'(pos) * 10) / len;
        if (frac > FULL_FRAC)
          frac = FULL_FRAC;
        px.x     = cur_x;
        px.y     = cur_y;
        px.color = blend(frac);
        px.last  = 1'b0;
        e2 = 2 * err;
        if (e2 > -span_y) begin
          err   -= span_y;
          cur_x = neg_x ? cur_x - 1'b1 : cur_x + 1'b1;
        end
        if (e2 < span_x) begin
          err   += span_x;
          cur_y = neg_y ? cur_y - 1'b1 : cur_y + 1'b1;
        end
      end
      expected_pixels.push_back(px);
      return 1;
    endfunction

    function void check_result(pixel_t got);
      pixel_t exp_px;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: x %0d, y %0d", $signed(got.x), $signed(got.y));
        failures++;
        return;
      end
      exp_px = expected_pixels.pop_front();
      if (got.x !== exp_px.x) begin
        $error("pixel_x: expected %0d, actual %0d", $signed(exp_px.x), $signed(got.x));
        failures++;
      end
      if (got.y !== exp_px.y) begin
        $error("pixel_y: expected %0d, actual %0d", $signed(exp_px.y), $signed(got.y));
        failures++;
      end
      if (got.color !== exp_px.color) begin
        $error("pixel_color: expected %h, actual %h", exp_px.color, got.color);
        failures++;
      end
      if (got.last !== exp_px.last) begin
        $error("last_pixel: expected %b, actual %b", exp_px.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [glr_pkg::WIDTH_BITS-1:0] cfg_wdata_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [IN_W-1:0]                s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [OUT_W-1:0]               m_axis_tdata;
  logic                           m_axis_tlast;

  pixel_scoreboard sb;
  pixel_t          seen_pixel;
  int              cur_width = int'(glr_pkg::WIDTH_RESET);
  int              send_idle_pct = IDLE_NONE;
  int              stall_pct = IDLE_NONE;
  int              sent_beats = 0;
  int              hold_requests = 0;
  int              hold_served = 0;
  int              hold_left = 0;
  int              cycle_count = 0;

  gradient_line_rasterizer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Output side: check each accepted pixel, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_pixel.x     = m_axis_tdata[COORD_W-1:0];
      seen_pixel.y     = m_axis_tdata[2*COORD_W-1:COORD_W];
      seen_pixel.color = m_axis_tdata[2*COORD_W +: 32];
      seen_pixel.last  = m_axis_tlast;
      sb.check_result(seen_pixel);
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int clamp_coord(int v);
    if (v < COORD_MIN)
      return COORD_MIN;
    if (v > COORD_MAX)
      return COORD_MAX;
    return v;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
  endfunction

  function automatic int walk_len(int xs, int ys, int xe, int ye);
    int dx, dy;
    dx = (xe > xs) ? xe - xs : xs - xe;
    dy = (ye > ys) ? ye - ys : ys - ye;
    return (dx > dy) ? dx : dy;
  endfunction

  // Present one beat, optionally after idle cycles, and wait for acceptance.
  task automatic send_beat(input logic cmd, input int xs, ys, xe, ye,
                           input logic [31:0] sc, ec);
    logic [COORD_W-1:0] bx, by, ex, ey;
    bx = COORD_W'(xs);
    by = COORD_W'(ys);
    ex = COORD_W'(xe);
    ey = COORD_W'(ye);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= IN_W'({ec, sc, ey, ex, by, bx});
    do @(posedge clk_i); while (!s_axis_tready);
    void'(sb.note_input(cmd, bx, by, ex, ey, sc, ec));
    sent_beats++;
  endtask

  // Step beats carry random payload, which the block must ignore.
  task automatic step_line(input int n);
    repeat (n)
      send_beat(glr_pkg::CMD_STEP, any_coord(), any_coord(), any_coord(), any_coord(),
                $urandom, $urandom);
  endtask

  task automatic walk_line(input int xs, ys, xe, ye, input logic [31:0] sc, ec,
                           input int extra);
    send_beat(glr_pkg::CMD_START, xs, ys, xe, ye, sc, ec);
    step_line(walk_len(xs, ys, xe, ye) + 1 + extra);
  endtask

  // Stop sending, let every pixel arrive, then give the core time to go idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_width(input int w);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= glr_pkg::WIDTH_BITS'(w);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_width = w;
    sb.set_width(w);
  endtask

  // Mostly complete short lines near the window, plus abandoned, rejected
  // and random beats.
  task automatic random_phase(input int target);
    int goal, r, xs, ys, xe, ye, reach;
    goal = sent_beats + target;
    while (sent_beats < goal) begin
      r = $urandom_range(99);
      if (r < 62) begin
        xs = ($urandom_range(9) < 7) ?
             clamp_coord(int'($urandom_range(0, cur_width + 16)) - 8) : any_coord();
        ys    = any_coord();
        reach = ($urandom_range(7) == 0) ? 60 : 10;
        xe = clamp_coord(xs + int'($urandom_range(0, 2 * reach)) - reach);
        ye = clamp_coord(ys + int'($urandom_range(0, 2 * reach)) - reach);
        walk_line(xs, ys, xe, ye, $urandom, $urandom, int'($urandom_range(3) == 0));
      end else if (r < 80) begin
        // Long line that the next start abandons part way.
        send_beat(glr_pkg::CMD_START, any_coord(), any_coord(), any_coord(), any_coord(),
                  $urandom, $urandom);
        step_line($urandom_range(1, 6));
      end else if (r < 90) begin
        if ($urandom_range(1) == 0 || cur_width >= COORD_MAX) begin
          xs = -int'($urandom_range(1, -COORD_MIN));
          xe = -int'($urandom_range(1, -COORD_MIN));
        end else begin
          xs = $urandom_range(cur_width + 1, COORD_MAX);
          xe = $urandom_range(cur_width + 1, COORD_MAX);
        end
        send_beat(glr_pkg::CMD_START, xs, any_coord(), xe, any_coord(), $urandom, $urandom);
        step_line($urandom_range(1, 2));
      end else begin
        send_beat(1'($urandom_range(1)), any_coord(), any_coord(), any_coord(), any_coord(),
                  $urandom, $urandom);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle step, zero-length line, rejections on both sides,
    // a start exactly at the window edge, full-range endpoints, a short walk.
    step_line(1);
    walk_line(5, 7, 5, 7, 32'h12345678, 32'hFFFFFFFF, 1);
    send_beat(glr_pkg::CMD_START, COORD_MIN, 0, -1, 0, 32'hFFFFFFFF, 32'h0);
    step_line(1);
    send_beat(glr_pkg::CMD_START, 1921, 0, COORD_MAX, 0, 32'h0, 32'hFFFFFFFF);
    step_line(1);
    send_beat(glr_pkg::CMD_START, 1920, 3, COORD_MAX, 9, 32'h80FF0080, 32'h0000FF7F);
    step_line(2);
    send_beat(glr_pkg::CMD_START, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
              32'h00000000, 32'hFFFFFFFF);
    step_line(3);
    walk_line(0, 0, 3, -2, 32'hFF00FF00, 32'h00FF00FF, 1);
    settle();

    write_width(WIDTH_MAX);
    random_phase(190);
    settle();

    write_width(1);
    send_idle_pct = IDLE_HEAVY;
    random_phase(190);
    settle();

    write_width($urandom_range(1, WIDTH_MAX));
    send_idle_pct = IDLE_NONE;
    stall_pct     = IDLE_HEAVY;
    random_phase(190);
    settle();

    write_width(int'(glr_pkg::WIDTH_RESET));
    send_idle_pct = IDLE_BOTH;
    stall_pct     = IDLE_BOTH;
    random_phase(190);
    settle();

    // Long output hold-off while a long line keeps the input busy.
    write_width(100);
    send_idle_pct = IDLE_NONE;
    stall_pct     = IDLE_NONE;
    hold_requests++;
    walk_line(0, 0, 60, 25, 32'h40102030, 32'hC0F0E0D0, 0);
    random_phase(190);
    settle();

    if (sb.failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/glr_pkg.sv
hw/rtl/glr_divider.sv
hw/rtl/glr_datapath.sv
hw/rtl/glr_ctrl.sv
hw/rtl/gradient_line_rasterizer_core.sv
dv/gradient_line_rasterizer_core_tb.sv
